### hdl/lfulru_pkg.sv
package lfulru_pkg;

  // Width of the global use stamp
  localparam int STAMP_BITS = 64;

  // Item codes carried on kind
  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_ACCESS = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

endpackage

### hdl/lfu_lru_tiebreak_replacement.sv
// LFU replacement state with LRU tie-break for a set-associative cache.
//
// Command channel: a word (kind, set_index, way_index, hit, is_write) is taken
// at a rising edge with start high and busy low. A fill, or an access update
// that hit and is not a write, bumps the way's saturating use count and gives
// it the current global stamp. A victim query answers on victim_way with a
// one-cycle done strobe; the receiver cannot stall, so the word must be taken
// in that cycle.
//
// Each (set, way) entry sits in one synchronous memory, one entry per address.
// Timing is set by its single port:
//   fill / access update : read the entry, then write it back
//   victim query         : read way 0, then compare one way read per cycle
//                          across all WAYS ways; done rises after the last compare
//   ignored words, queries to a set beyond SETS : handled in idle (done next cycle
//                          for such a query, answering way 0)
// Reset: rst (synchronous) starts a clearing pass that zeroes every entry, one
// per cycle, across all DEPTH = 2^(SB+WB) entries (16384 at the defaults); busy
// stays high until it ends.
module lfu_lru_tiebreak_replacement #(
  parameter int SETS       = 1024,
  parameter int WAYS       = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind,
  input  logic [9:0]                set_index,
  input  logic [3:0]                way_index,
  input  logic                      hit,
  input  logic                      is_write,
  output logic                      done,
  output logic [3:0]                victim_way
);

  localparam int SB    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WB    = $clog2(WAYS);
  localparam int AW    = SB + WB;
  localparam int DEPTH = 1 << AW;
  localparam int SXB   = (SB > 10) ? SB : 10;
  localparam int WXB   = (WB > 4) ? WB : 4;
  localparam int KW    = COUNT_BITS + lfulru_pkg::STAMP_BITS;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_SCAN
  } state_t;

  state_t state;

  // Entry memory: {use count, stamp}
  logic [KW-1:0] mem [DEPTH];
  logic [KW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_data;
  logic          wr_en;

  logic [AW-1:0]                       clr_addr;
  logic [AW-1:0]                       entry_addr;
  logic [SB-1:0]                       set_r;
  logic [WB-1:0]                       cmp_way;
  logic [KW-1:0]                       best_key;
  logic [WB-1:0]                       best_way;
  logic [lfulru_pkg::STAMP_BITS-1:0]   stamp_counter;

  logic [SXB-1:0]    set_wide;
  logic [WXB-1:0]    way_wide;
  logic [SB-1:0]     set_sel;
  logic [WB-1:0]     way_sel;
  logic              set_ok;
  logic              way_ok;
  logic              accept;
  logic              is_query;
  logic              is_touch;
  logic [WB-1:0]     next_way;
  logic              take;
  logic [WB-1:0]     final_way;
  logic [COUNT_BITS-1:0] old_count;
  logic [COUNT_BITS-1:0] count_next;

  // Decode the incoming word
  assign set_wide = SXB'(set_index);
  assign way_wide = WXB'(way_index);
  assign set_sel  = set_wide[SB-1:0];
  assign way_sel  = way_wide[WB-1:0];
  assign set_ok   = 32'(set_index) < SETS;
  assign way_ok   = 32'(way_index) < WAYS;
  assign accept   = start && !busy;
  assign is_query = kind == lfulru_pkg::KIND_QUERY;
  assign is_touch = set_ok && way_ok &&
                    ((kind == lfulru_pkg::KIND_FILL) ||
                     ((kind == lfulru_pkg::KIND_ACCESS) && hit && !is_write));

  assign busy = (state != S_IDLE);

  // Pick the read address: way 0 of a queried set, the touched way, or the next scan way
  assign next_way = cmp_way + WB'(1);
  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = {set_r, next_way};
    end else if (is_query) begin
      rd_addr = {set_sel, WB'(0)};
    end else begin
      rd_addr = {set_sel, way_sel};
    end
  end

  // Bump the count with saturation
  assign old_count  = rd_data[KW-1:lfulru_pkg::STAMP_BITS];
  assign count_next = (&old_count) ? old_count : old_count + COUNT_BITS'(1);

  // Select write port source: clearing pass or touch write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = entry_addr;
    wr_data = {count_next, stamp_counter};
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_WRITE: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Compare the way in rd_data against the best so far
  assign take      = (cmp_way == WB'(0)) || (rd_data < best_key);
  assign final_way = take ? cmp_way : best_way;

  // Memory port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Control, stamp counter and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      stamp_counter <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            set_r      <= set_sel;
            entry_addr <= {set_sel, way_sel};
            cmp_way    <= '0;
            if (is_query) begin
              if (set_ok) begin
                state <= S_SCAN;
              end else begin
                done       <= 1'b1;
                victim_way <= '0;
              end
            end else if (is_touch) begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          stamp_counter <= stamp_counter + lfulru_pkg::STAMP_BITS'(1);
          state         <= S_IDLE;
        end
        S_SCAN: begin
          best_key <= take ? rd_data : best_key;
          best_way <= final_way;
          cmp_way  <= next_way;
          if (cmp_way == WB'(WAYS - 1)) begin
            done       <= 1'b1;
            victim_way <= 4'(final_way);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result only follows the last scan step or a query to a set out of range
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_SCAN || (start && !busy)))
    else $error("result strobe without a finished query");

  // Each write-back advances the stamp by one
  a_stamp_step: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |=> stamp_counter == $past(stamp_counter) + 64'd1)
    else $error("stamp did not advance on write-back");

  // The stamp moves only on a write-back
  a_stamp_hold: assert property (@(posedge clk) disable iff (rst)
    !$stable(stamp_counter) |-> $past(state == S_WRITE))
    else $error("stamp changed outside write-back");

  // The scan never looks past the last way
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> 32'(cmp_way) < WAYS)
    else $error("scan way out of range");

endmodule
